/* rtl/core/irm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_pkg
// shared constants and controller/datapath interface types for the
// interval range map
// ----------------------------------------------------------------------------
package irm_pkg;

  localparam int unsigned MaxBoundariesDflt = 32;

  // command codes
  localparam logic CmdAssign = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // result status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval1;
    logic push_s;
    logic push_e;
    logic idx_clr;
    logic eval2;
    logic finish;
  } irm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_assign_empty;
    logic is_lookup;
    logic idx_done;
    logic out_full;
  } irm_stat_t;

endpackage

/* rtl/core/irm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module irm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/irm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_ctrl
// sequencer for lookup scan, assign merge passes and result hand-off
// ----------------------------------------------------------------------------
module irm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  irm_pkg::irm_stat_t stat_i,
  output irm_pkg::irm_cmd_t  cmd_o
);
  import irm_pkg::*;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StRd1  = 8'b0000_0010,
    StEv1  = 8'b0000_0100,
    StPs   = 8'b0000_1000,
    StPe   = 8'b0001_0000,
    StRd2  = 8'b0010_0000,
    StEv2  = 8'b0100_0000,
    StFin  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = stat_i.in_assign_empty ? StFin : StRd1;
        end
      end
      StRd1: begin
        if (stat_i.idx_done) begin
          state_d = stat_i.is_lookup ? StFin : StPs;
        end else begin
          state_d = StEv1;
        end
      end
      StEv1: begin
        cmd_o.eval1 = 1'b1;
        state_d = StRd1;
      end
      StPs: begin
        cmd_o.push_s = 1'b1;
        state_d = StPe;
      end
      StPe: begin
        cmd_o.push_e  = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d = StRd2;
      end
      StRd2: begin
        state_d = stat_i.idx_done ? StFin : StEv2;
      end
      StEv2: begin
        cmd_o.eval2 = 1'b1;
        state_d = StRd2;
      end
      StFin: begin
        if (!stat_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

/* rtl/core/irm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_dp
// boundary table banks, scan compare, merge push and output register
// ----------------------------------------------------------------------------
module irm_dp #(
  parameter int unsigned MAX_BOUNDARIES = irm_pkg::MaxBoundariesDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               command_i,
  input  logic signed [31:0] key_start_i,
  input  logic signed [31:0] key_stop_i,
  input  logic [7:0]         new_value_i,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_data_i,
  output logic [7:0]         read_value_o,
  output logic [1:0]         status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  irm_pkg::irm_cmd_t  cmd_i,
  output irm_pkg::irm_stat_t stat_o
);
  import irm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BOUNDARIES);
  localparam int unsigned CW = $clog2(MAX_BOUNDARIES + 2);
  localparam logic [CW-1:0] MaxC = CW'(MAX_BOUNDARIES);

  logic               cmd_q;
  logic signed [31:0] ks_q, ke_q;
  logic [7:0]         nv_q, acc_q, prev_q, dflt_q;
  logic               empty_q, bank_q;
  logic [CW-1:0]      scnt_q, idx_q, n_q;
  logic               out_valid_q;
  logic [7:0]         rv_q;
  logic [1:0]         st_q;

  logic [39:0]        rdata0, rdata1, rdata;
  logic signed [31:0] rkey;
  logic [7:0]         rval;
  logic               push_en, do_push, we;
  logic [31:0]        push_k;
  logic [7:0]         push_v;
  logic               commit;

  irm_ram #(.WIDTH(40), .DEPTH(MAX_BOUNDARIES)) u_ram0 (
    .clk_i  (clk_i),
    .we_i   (we && bank_q),
    .waddr_i(scnt_q[AW-1:0]),
    .wdata_i({push_k, push_v}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata0)
  );

  irm_ram #(.WIDTH(40), .DEPTH(MAX_BOUNDARIES)) u_ram1 (
    .clk_i  (clk_i),
    .we_i   (we && !bank_q),
    .waddr_i(scnt_q[AW-1:0]),
    .wdata_i({push_k, push_v}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata1)
  );

  assign rdata = bank_q ? rdata1 : rdata0;
  assign rkey  = $signed(rdata[39:8]);
  assign rval  = rdata[7:0];

  // merge push into the idle bank, equal neighbours dropped
  always_comb begin
    push_en = 1'b0;
    push_k  = rkey;
    push_v  = rval;
    if (cmd_i.eval1 && (cmd_q == CmdAssign) && (rkey < ks_q)) begin
      push_en = 1'b1;
    end
    if (cmd_i.eval2 && (rkey > ke_q)) begin
      push_en = 1'b1;
    end
    if (cmd_i.push_s) begin
      push_en = 1'b1;
      push_k  = ks_q;
      push_v  = nv_q;
    end
    if (cmd_i.push_e) begin
      push_en = 1'b1;
      push_k  = ke_q;
      push_v  = acc_q;
    end
  end

  assign do_push = push_en && (push_v != prev_q);
  assign we      = do_push && (scnt_q < MaxC);
  assign commit  = cmd_i.finish && (cmd_q == CmdAssign) && !empty_q && (scnt_q <= MaxC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      ks_q  <= key_start_i;
      ke_q  <= key_stop_i;
      nv_q  <= new_value_i;
    end
    if (cmd_i.finish) begin
      rv_q <= (cmd_q == CmdLookup) ? acc_q : 8'd0;
      if (cmd_q == CmdLookup) begin
        st_q <= StatusOk;
      end else if (empty_q) begin
        st_q <= StatusEmpty;
      end else if (scnt_q > MaxC) begin
        st_q <= StatusFull;
      end else begin
        st_q <= StatusOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q     <= 1'b0;
      acc_q       <= '0;
      prev_q      <= '0;
      scnt_q      <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      bank_q      <= 1'b0;
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        empty_q <= !(key_start_i < key_stop_i);
        acc_q   <= dflt_q;
        prev_q  <= dflt_q;
        scnt_q  <= '0;
        idx_q   <= '0;
      end else begin
        if (cmd_i.eval1) begin
          if (rkey <= ((cmd_q == CmdLookup) ? ks_q : ke_q)) begin
            acc_q <= rval;
          end
        end
        if (cmd_i.eval1 || cmd_i.eval2) begin
          idx_q <= idx_q + 1'b1;
        end
        if (cmd_i.idx_clr) begin
          idx_q <= '0;
        end
        if (do_push) begin
          prev_q <= push_v;
          if (scnt_q <= MaxC) begin
            scnt_q <= scnt_q + 1'b1;
          end
        end
      end
      if (commit) begin
        bank_q <= !bank_q;
        n_q    <= scnt_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.in_assign_empty = (command_i == CmdAssign) && !(key_start_i < key_stop_i);
  assign stat_o.is_lookup       = (cmd_q == CmdLookup);
  assign stat_o.idx_done        = (idx_q >= n_q);
  assign stat_o.out_full        = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

endmodule

/* rtl/core/interval_range_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_map
// piecewise constant map of signed 32-bit keys to 8-bit values
// ----------------------------------------------------------------------------
// a word is scanned against the stored boundaries in one read/compare step per
//   table entry on the single ram read port; an assign adds a merge pass and
//   an empty assign skips both passes
// one word at a time: the input is held until the result is loaded into the
//   output register, longer while an earlier result still waits there
// reset: boundary count cleared, default value 0; table rams are not cleared
module interval_range_map #(
  parameter int unsigned MAX_BOUNDARIES = irm_pkg::MaxBoundariesDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic signed [31:0] key_start_i,
  input  logic signed [31:0] key_stop_i,
  input  logic [7:0]  new_value_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_value_o,
  output logic [1:0]  status_o,
  // default value register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import irm_pkg::*;

  irm_cmd_t  cmd;
  irm_stat_t stat;

  // register always writable
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, scan pass, interval pushes, tail pass, hand-off
  irm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // two table banks: live one read, the other rebuilt, swapped on commit
  irm_dp #(.MAX_BOUNDARIES(MAX_BOUNDARIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .key_start_i (key_start_i),
    .key_stop_i  (key_stop_i),
    .new_value_i (new_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef SYNTH
  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted word did not make block busy");

  // result only loaded into a free output register
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_valid_o)
    else $error("result overwrote pending word");

  // each compare step waits for a fresh ram read
  a_eval_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.eval1 || cmd.eval2) |=> !(cmd.eval1 || cmd.eval2))
    else $error("back to back compare steps");
`endif

endmodule

/* test/interval_range_map_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_map_checker
// watches the input, result and default value channels, keeps its own copy of
// the boundary table and compares every result word with the predicted one
// ----------------------------------------------------------------------------
module interval_range_map_checker #(
  parameter int unsigned MAX_BOUNDARIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic signed [31:0] key_start_i,
  input  logic signed [31:0] key_stop_i,
  input  logic [7:0]         new_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         read_value_i,
  input  logic [1:0]         status_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import irm_pkg::*;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } map_result_t;

  logic signed [31:0] map_keys[MAX_BOUNDARIES];
  logic [7:0]         map_vals[MAX_BOUNDARIES];
  int                 map_count;
  logic [7:0]         dflt_value;
  map_result_t        expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [7:0] value_at_key(logic signed [31:0] k);
    logic [7:0] v;
    v = dflt_value;
    for (int i = 0; i < map_count; i++) begin
      if (map_keys[i] > k) break;
      v = map_vals[i];
    end
    return v;
  endfunction

  // rebuild the table into a scratch list, dropping repeats of the value below
  function automatic logic [1:0] assign_range(logic signed [31:0] s, logic signed [31:0] e,
                                              logic [7:0] v);
    logic signed [31:0] nk[$];
    logic [7:0]         nv[$];
    logic [7:0]         prev;
    logic [7:0]         after_stop;
    if (!(s < e)) return StatusEmpty;
    after_stop = value_at_key(e);
    prev = dflt_value;
    for (int i = 0; i < map_count; i++)
      if (map_keys[i] < s && map_vals[i] != prev) begin
        nk.push_back(map_keys[i]); nv.push_back(map_vals[i]); prev = map_vals[i];
      end
    if (v != prev) begin
      nk.push_back(s); nv.push_back(v); prev = v;
    end
    if (after_stop != prev) begin
      nk.push_back(e); nv.push_back(after_stop); prev = after_stop;
    end
    for (int i = 0; i < map_count; i++)
      if (map_keys[i] > e && map_vals[i] != prev) begin
        nk.push_back(map_keys[i]); nv.push_back(map_vals[i]); prev = map_vals[i];
      end
    if (nk.size() > MAX_BOUNDARIES) return StatusFull;
    foreach (nk[i]) begin
      map_keys[i] = nk[i];
      map_vals[i] = nv[i];
    end
    map_count = nk.size();
    return StatusOk;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t r;
    map_result_t w;
    if (!rst_ni) begin
      map_count    = 0;
      dflt_value   = 8'd0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) dflt_value = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CmdLookup) begin
          r.read_value = value_at_key(key_start_i);
          r.status     = StatusOk;
        end else begin
          r.read_value = 8'd0;
          r.status     = assign_range(key_start_i, key_stop_i, new_value_i);
        end
        expected_results.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word, status", status_i, 0);
        end else begin
          w = expected_results.pop_front();
          if (read_value_i !== w.read_value) report_mismatch("read_value", read_value_i,
                                                             w.read_value);
          if (status_i !== w.status) report_mismatch("status", status_i, w.status);
        end
      end
    end
  end
endmodule

/* test/interval_range_map_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_map_test
// drives directed and random assign/lookup words through the interval map
// under several idle and stall mixes, with default value rewrites between
// phases; a separate checker predicts and compares every result word
// ----------------------------------------------------------------------------
module interval_range_map_test;
  import irm_pkg::*;

  localparam int unsigned MaxB = 32;
  // limit covers the longest assign word plus long receiver stalls
  localparam int WatchdogLimit = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CmdLookup;
  logic signed [31:0] key_start = '0;
  logic signed [31:0] key_stop = '0;
  logic [7:0]         new_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         read_value;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;
  int                 fail_count;
  int                 pending;

  // idle odds in percent for the sender and the receiver
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 idle_cycles = 0;

  always #1 clk = ~clk;

  interval_range_map #(.MAX_BOUNDARIES(MaxB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .command_i(command),
    .key_start_i(key_start), .key_stop_i(key_stop), .new_value_i(new_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_value_o(read_value), .status_o(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  interval_range_map_checker #(.MAX_BOUNDARIES(MaxB)) i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .command_i(command),
    .key_start_i(key_start), .key_stop_i(key_stop), .new_value_i(new_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .read_value_i(read_value), .status_i(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random, re-rolled every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: cycles with no accepted word at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("interval_range_map regression: fail");
      $finish;
    end
  end

  // one word: optional random gap, then hold valid until accepted;
  // valid stays up on return so the next word can follow directly
  task automatic send_word(logic cmd, logic signed [31:0] ks, logic signed [31:0] ke,
                           logic [7:0] nv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    key_start <= ks;
    key_stop  <= ke;
    new_value <= nv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for all results, then a short tail before touching the register
  task automatic write_default(logic [7:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // keys drawn from a narrow pool so intervals overlap and merge often
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'sh7fffffff - $urandom_range(3);
      2:       return 32'sh80000000 + $urandom_range(3);
      default: return $signed($urandom_range(80)) - 40;
    endcase
  endfunction

  task automatic random_phase(int count);
    logic signed [31:0] a;
    logic signed [31:0] b;
    for (int i = 0; i < count; i++) begin
      a = pick_key();
      b = pick_key();
      if ($urandom_range(9) < 8 && a > b) begin
        a ^= b; b ^= a; a ^= b;
      end
      send_word(1'($urandom_range(1)), a, b,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, empty interval, merges and a lookup at each end
    write_default(8'hff);
    send_word(CmdLookup, 32'sh80000000, 0, 0);
    send_word(CmdAssign, 32'sh80000000, 32'sh7fffffff, 8'h00);
    send_word(CmdLookup, 32'sh7fffffff, 0, 8'hff);
    send_word(CmdLookup, 32'sh80000000, 32'sh7fffffff, 0);
    send_word(CmdAssign, 10, 10, 8'h55);
    send_word(CmdAssign, 20, -5, 8'haa);
    send_word(CmdAssign, -10, 10, 8'hff);
    send_word(CmdAssign, 0, 5, 8'hff);
    send_word(CmdAssign, 5, 20, 8'h00);
    send_word(CmdLookup, 4, 0, 0);
    send_word(CmdLookup, 5, 0, 0);
    send_word(CmdLookup, 20, 0, 0);
    send_word(CmdAssign, -1, 32'sh7fffffff, 8'hff);
    // table full: alternating one-key intervals
    for (int k = 0; k < 20; k++) send_word(CmdAssign, 2 * k, 2 * k + 1, 8'(k + 1));
    send_word(CmdLookup, 7, 0, 0);

    // default changed while boundaries are stored
    write_default(8'h00);
    send_word(CmdLookup, -100, 0, 0);
    send_word(CmdAssign, 100, 101, 8'h01);

    write_default(8'd0);
    random_phase(300);
    write_default(8'd1);
    send_idle_pct = 84;
    random_phase(300);
    write_default(8'd2);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    random_phase(300);
    write_default(8'($urandom));
    send_idle_pct = 27;
    recv_stall_pct = 27;
    random_phase(300);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("interval_range_map regression: pass");
    else
      $display("interval_range_map regression: fail");
    $finish;
  end
endmodule
